>>> rtl/fot_pkg.sv
// Shared types, codes and helpers for the feed owner table.
`timescale 1ns / 1ps
`default_nettype none

package fot_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int ID_W        = 31;
	localparam int PORT_W      = 16;
	localparam int MASK_W      = 32;
	localparam int LIMIT_W     = 32;

	typedef enum logic [1:0] {
		MODE_CLAIM   = 2'd0,
		MODE_LOOKUP  = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_INVALID   = 2'd1,
		STAT_DUP       = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] tport;
		logic [PORT_W-1:0] sport;
	} entry_t;

	typedef struct packed {
		mode_t             mode;
		logic [MASK_W-1:0] feed_mask;
		logic [ID_W-1:0]   owner_id;
		logic [PORT_W-1:0] transfer_port;
		logic [PORT_W-1:0] service_port;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   found_id;
		logic [PORT_W-1:0] found_transfer_port;
		logic [PORT_W-1:0] found_service_port;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             inv_en;
		logic [IDX_W-1:0] inv_addr;
		logic             clr_all;
	} store_req_t;

	typedef struct packed {
		logic   vld;
		entry_t entry;
	} store_rsp_t;

	// entry is in the claim/lookup range when its single-bit mask value <= limit
	function automatic logic in_scan(input logic [LIMIT_W-1:0] limit,
			input logic [IDX_W-1:0] idx);
		return (limit >> idx) != '0;
	endfunction

endpackage

`default_nettype wire

>>> rtl/feed_owner_table_top.sv
// Feed owner table: stream ports, limit register and the table core.
//
// One request in, one response out. A request is taken only while the table
// is idle, but a finished response waits in its own register so the next
// request can go in before it is taken. Every entry sits in a synchronous
// memory with one read and one write port that is swept one entry per cycle:
// lookup and release take one sweep of all 32 entries, a successful claim a
// check sweep then a write sweep, a failed claim the check sweep only, and
// clear and a zero-id claim go without any sweep. Occupied bits
// are held in flops, so reset and clear are immediate and no clearing pass
// is run. The feed_limit register may be written at any time the table is
// idle and is taken in a single cycle.
`timescale 1ns / 1ps
`default_nettype none

module feed_owner_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,      // feed_limit
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // feed_mask, owner_id, transfer_port, service_port
	input  wire logic [1:0]  s_axis_tuser,  // mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata   // status, found_id, found_transfer_port, found_service_port
);
	import fot_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	item_t              in_item;
	result_t            res;
	store_req_t         store_req;
	store_rsp_t         store_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign in_item.mode          = mode_t'(s_axis_tuser);
	assign in_item.feed_mask     = s_axis_tdata[31:0];
	assign in_item.owner_id      = s_axis_tdata[62:32];
	assign in_item.transfer_port = s_axis_tdata[78:63];
	assign in_item.service_port  = s_axis_tdata[94:79];

	fot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

	fot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.limit     (limit_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.store_req (store_req),
		.store_rsp (store_rsp)
	);

	assign m_axis_tdata = {7'd0, res.found_service_port, res.found_transfer_port,
		res.found_id, res.status};

endmodule

`default_nettype wire

>>> rtl/fot_store.sv
// Entry memory with per-entry occupied bits; one read, one write per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fot_store (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fot_pkg::store_req_t req,
	output fot_pkg::store_rsp_t      rsp
);
	import fot_pkg::*;

	entry_t                 mem_q [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;
	entry_t                 rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	// occupied bits: an entry that is not occupied reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_vld_q <= valid_q[req.rd_addr];
			end
			if (req.clr_all) begin
				valid_q <= '0;
			end else begin
				if (req.inv_en) begin
					valid_q[req.inv_addr] <= 1'b0;
				end
				if (req.wr_en) begin
					valid_q[req.wr_addr] <= 1'b1;
				end
			end
		end
	end

	assign rsp.vld   = rd_vld_q;
	assign rsp.entry = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> rtl/fot_ctrl.sv
// Operation sequencer: scan pass, claim write pass and result register.
`timescale 1ns / 1ps
`default_nettype none

module fot_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire fot_pkg::item_t              in_item,
	input  wire logic [fot_pkg::LIMIT_W-1:0] limit,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output fot_pkg::result_t                 out_res,
	output fot_pkg::store_req_t              store_req,
	input  wire fot_pkg::store_rsp_t         store_rsp
);
	import fot_pkg::*;

	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [MASK_W-1:0] mask_q;
	logic [ID_W-1:0]   id_q;
	logic [PORT_W-1:0] tport_q;
	logic [PORT_W-1:0] sport_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  cur_idx;
	logic              issue;
	logic              pipe_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              hit_q;
	entry_t            found_q;
	result_t           res_q, res_d;
	logic              out_vld_q;
	logic              accept;
	logic              load;
	logic              s1_scan;
	logic              s1_mask;
	logic              rel_match;

	assign cur_idx = cnt_q[IDX_W-1:0];
	assign issue   = (state_q == S_SCAN) && (cnt_q < CNT_W'(NUM_ENTRIES));
	assign s1_scan = in_scan(limit, idx_s1);
	assign s1_mask = mask_q[idx_s1];
	// an empty entry reads as id zero, so a zero id matches the empty entries
	assign rel_match = store_rsp.vld ? (store_rsp.entry.id == id_q) : (id_q == '0);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		load      = 1'b0;
		store_req = '0;
		store_req.rd_addr  = cur_idx;
		store_req.wr_addr  = cur_idx;
		store_req.wr_data  = '{id: id_q, tport: tport_q, sport: sport_q};
		store_req.inv_addr = idx_s1;
		store_req.inv_en   = pipe_s1 && (mode_q == MODE_RELEASE) && rel_match;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_item.mode == MODE_CLEAR) begin
						store_req.clr_all = 1'b1;
						state_d = S_DONE;
					end else if (in_item.mode == MODE_CLAIM && in_item.owner_id == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				store_req.rd_en = issue;
				if (!issue && !pipe_s1) begin
					state_d = (mode_q == MODE_CLAIM && !hit_q) ? S_WRITE : S_DONE;
				end
			end
			S_WRITE: begin
				store_req.wr_en = in_scan(limit, cur_idx) && mask_q[cur_idx];
				if (cur_idx == IDX_W'(NUM_ENTRIES - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_vld_q || out_ready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		res_d = '0;
		case (mode_q)
			MODE_CLAIM: begin
				if (id_q == '0) begin
					res_d.status = STAT_INVALID;
				end else begin
					res_d.status = hit_q ? STAT_DUP : STAT_OK;
				end
			end
			MODE_LOOKUP: begin
				res_d.status              = hit_q ? STAT_OK : STAT_NOT_FOUND;
				res_d.found_id            = found_q.id;
				res_d.found_transfer_port = found_q.tport;
				res_d.found_service_port  = found_q.sport;
			end
			MODE_RELEASE: res_d.status = hit_q ? STAT_OK : STAT_NOT_FOUND;
			default:      res_d.status = STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			pipe_s1   <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pipe_s1 <= issue;
			if (accept) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else if (state_q == S_SCAN && state_d == S_WRITE) begin
				cnt_q <= '0;
			end else if (issue || state_q == S_WRITE) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pipe_s1) begin
				case (mode_q)
					MODE_CLAIM: begin
						if (s1_scan && store_rsp.vld &&
								(store_rsp.entry.id == id_q || s1_mask)) begin
							hit_q <= 1'b1;
						end
					end
					MODE_LOOKUP: begin
						if (s1_scan && store_rsp.vld && s1_mask) begin
							hit_q <= 1'b1;
						end
					end
					MODE_RELEASE: begin
						if (rel_match) begin
							hit_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_item.mode;
			mask_q  <= in_item.feed_mask;
			id_q    <= in_item.owner_id;
			tport_q <= in_item.transfer_port;
			sport_q <= in_item.service_port;
			found_q <= '0;
		end else if (pipe_s1 && mode_q == MODE_LOOKUP && !hit_q &&
				s1_scan && store_rsp.vld && s1_mask) begin
			// first hit in bit order wins
			found_q <= store_rsp.entry;
		end
		idx_s1 <= cur_idx;
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_res   = res_q;

	a_write_only_in_write_pass: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.wr_en |-> (state_q == S_WRITE) && (mode_q == MODE_CLAIM) && !hit_q)
		else $error("table write outside claim write pass");

	a_inv_only_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.inv_en |-> (mode_q == MODE_RELEASE) && (state_q == S_SCAN))
		else $error("entry emptied outside release scan");

	a_found_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_d.found_id != '0) |-> (mode_q == MODE_LOOKUP) && hit_q)
		else $error("found id reported outside a lookup hit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> $stable(res_q))
		else $error("pending result overwritten");

	a_no_read_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !issue) |-> !store_req.rd_en)
		else $error("read issued past the last entry");

endmodule

`default_nettype wire

>>> bench/tb_feed_owner_table_top.sv
// Self-checking bench for the feed owner table: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_feed_owner_table_top;
	import fot_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int MAX_SHOWN  = 10;
	localparam int POOL_SIZE  = 8;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [31:0]       cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [95:0]       s_axis_tdata;   // feed_mask, owner_id, transfer_port, service_port
	logic [1:0]        s_axis_tuser;   // mode
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [71:0]       m_axis_tdata;   // status, found_id, found_transfer_port, found_service_port

	// bench copy of the table and its limit register
	logic [ID_W-1:0]    tbl_id    [NUM_ENTRIES];
	logic [PORT_W-1:0]  tbl_tport [NUM_ENTRIES];
	logic [PORT_W-1:0]  tbl_sport [NUM_ENTRIES];
	logic [LIMIT_W-1:0] limit_shadow;

	result_t         expected_q[$];
	logic [ID_W-1:0] id_pool[POOL_SIZE];
	int              fail_count    = 0;
	int              src_idle_pct  = 0;
	int              snk_stall_pct = 0;

	feed_owner_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(1_500_000 * CLK_PERIOD);
		$display("Regression FAIL");
		$finish;
	end

	function automatic bit in_range(input int i);
		return i < 64 && (64'd1 << i) <= {32'd0, limit_shadow};
	endfunction

	function automatic bit mask_bit(input logic [MASK_W-1:0] mask, input int i);
		return i < MASK_W && mask[i];
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			tbl_id[i]    = '0;
			tbl_tport[i] = '0;
			tbl_sport[i] = '0;
		end
	endfunction

	// applies one request to the bench table and returns the response it should give
	function automatic result_t table_apply(input mode_t m, input logic [MASK_W-1:0] mask,
			input logic [ID_W-1:0] id, input logic [PORT_W-1:0] tp,
			input logic [PORT_W-1:0] sp);
		result_t r;
		r = '0;
		r.status = STAT_OK;
		case (m)
			MODE_CLAIM: begin
				if (id == '0) begin
					r.status = STAT_INVALID;
				end else begin
					for (int i = 0; i < NUM_ENTRIES && in_range(i); i++) begin
						if (tbl_id[i] != '0 && (tbl_id[i] == id || mask_bit(mask, i))) begin
							r.status = STAT_DUP;
							break;
						end
					end
					if (r.status == STAT_OK) begin
						for (int i = 0; i < NUM_ENTRIES && in_range(i); i++) begin
							if (mask_bit(mask, i)) begin
								tbl_id[i]    = id;
								tbl_tport[i] = tp;
								tbl_sport[i] = sp;
							end
						end
					end
				end
			end
			MODE_LOOKUP: begin
				r.status = STAT_NOT_FOUND;
				for (int i = 0; i < NUM_ENTRIES && in_range(i); i++) begin
					if (mask_bit(mask, i) && tbl_id[i] != '0) begin
						r.status              = STAT_OK;
						r.found_id            = tbl_id[i];
						r.found_transfer_port = tbl_tport[i];
						r.found_service_port  = tbl_sport[i];
						break;
					end
				end
			end
			MODE_RELEASE: begin
				// a zero id matches every empty entry
				r.status = STAT_NOT_FOUND;
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (tbl_id[i] == id) begin
						tbl_id[i]    = '0;
						tbl_tport[i] = '0;
						tbl_sport[i] = '0;
						r.status     = STAT_OK;
					end
				end
			end
			default: wipe_table();
		endcase
		return r;
	endfunction

	task automatic send_req(input mode_t m, input logic [MASK_W-1:0] mask,
			input logic [ID_W-1:0] id, input logic [PORT_W-1:0] tp,
			input logic [PORT_W-1:0] sp);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= {1'b0, sp, tp, id, mask};
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(table_apply(m, mask, id, tp, sp));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_feed_limit(input logic [LIMIT_W-1:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		limit_shadow = value;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return ID_W'($urandom);
		return id_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// lookups get denser masks so they hit more often
	function automatic logic [MASK_W-1:0] pick_mask(input bit dense);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < (dense ? 35 : 60))
			return 32'd1 << $urandom_range(MASK_W - 1);
		else if (r < (dense ? 50 : 85))
			return (32'd1 << $urandom_range(MASK_W - 1)) |
				(32'd1 << $urandom_range(MASK_W - 1)) |
				(32'd1 << $urandom_range(MASK_W - 1));
		return $urandom;
	endfunction

	task automatic send_random_item();
		int unsigned r;
		mode_t       m;
		r = $urandom_range(99);
		if (r < 38)
			m = MODE_CLAIM;
		else if (r < 72)
			m = MODE_LOOKUP;
		else if (r < 96)
			m = MODE_RELEASE;
		else
			m = MODE_CLEAR;
		send_req(m, pick_mask(m == MODE_LOOKUP), pick_id(), PORT_W'($urandom),
			PORT_W'($urandom));
	endtask

	task automatic test_claim_rules();
		send_req(MODE_LOOKUP, '1, '0, '0, '0);
		send_req(MODE_CLAIM, 32'h1, '0, 16'h1234, 16'h5678);
		send_req(MODE_CLAIM, 32'h1, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_req(MODE_CLAIM, 32'h8000_0000, 31'd1, 16'h0000, 16'h0000);
		send_req(MODE_CLAIM, 32'h20, 31'd1, 16'h0001, 16'h0002);   // same id elsewhere
		send_req(MODE_CLAIM, 32'h81, 31'd2, 16'h0003, 16'h0004);   // overlaps bit 0
		send_req(MODE_CLAIM, 32'h0, 31'd3, 16'h0005, 16'h0006);    // empty mask
	endtask

	task automatic test_lookup();
		send_req(MODE_LOOKUP, '1, '0, '0, '0);
		send_req(MODE_LOOKUP, 32'h8000_0000, '0, '0, '0);
		send_req(MODE_LOOKUP, 32'h0, '0, '0, '0);
	endtask

	task automatic test_release();
		send_req(MODE_RELEASE, '0, '0, '0, '0);
		send_req(MODE_RELEASE, '0, 31'h7FFF_FFFF, '0, '0);
		send_req(MODE_RELEASE, '0, 31'h7FFF_FFFF, '0, '0);
		send_req(MODE_RELEASE, '0, 31'd1, '0, '0);
		send_req(MODE_CLAIM, '1, 31'd5, 16'hAAAA, 16'h5555);
		send_req(MODE_RELEASE, '0, '0, '0, '0);                    // full table, no empties
	endtask

	task automatic test_clear();
		send_req(MODE_CLEAR, '1, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_req(MODE_LOOKUP, '1, '0, '0, '0);
	endtask

	task automatic test_feed_limit();
		set_feed_limit(32'h1);
		send_req(MODE_CLAIM, 32'h3, 31'd9, 16'h0909, 16'h9090);
		send_req(MODE_LOOKUP, 32'h2, '0, '0, '0);
		send_req(MODE_LOOKUP, 32'h3, '0, '0, '0);
		set_feed_limit(32'h0);
		send_req(MODE_LOOKUP, '1, '0, '0, '0);
		send_req(MODE_CLAIM, 32'h1, 31'd11, 16'h0B0B, 16'hB0B0);
		set_feed_limit(32'h8000_0000);
		send_req(MODE_CLAIM, 32'h8000_0002, 31'd12, 16'h0C0C, 16'hC0C0);
		send_req(MODE_LOOKUP, 32'h8000_0000, '0, '0, '0);
		set_feed_limit(32'h7FFF_FFFF);
		send_req(MODE_LOOKUP, 32'h8000_0000, '0, '0, '0);
	endtask

	task automatic test_random_traffic(input int n, input int src_pct, input int snk_pct,
			input logic [LIMIT_W-1:0] lim);
		set_feed_limit(lim);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		repeat (n) send_random_item();
	endtask

	// sender holds off until every response is back, receiver still stalling
	task automatic test_drain_pause();
		set_feed_limit('1);
		src_idle_pct  = 0;
		snk_stall_pct = 56;
		repeat (5) begin
			repeat (10) send_random_item();
			wait_drained();
		end
	endtask

	always @(posedge clk) begin : rsp_check
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("%0t: unexpected response %h", $time, m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tdata[1:0] !== want.status ||
							m_axis_tdata[32:2] !== want.found_id ||
							m_axis_tdata[48:33] !== want.found_transfer_port ||
							m_axis_tdata[64:49] !== want.found_service_port ||
							m_axis_tdata[71:65] !== '0) begin
						fail_count++;
						if (fail_count <= MAX_SHOWN)
							$display("%0t: exp %0d %h %h %h got %0d %h %h %h pad %h",
								$time,
								want.status, want.found_id, want.found_transfer_port,
								want.found_service_port, m_axis_tdata[1:0],
								m_axis_tdata[32:2], m_axis_tdata[48:33],
								m_axis_tdata[64:49], m_axis_tdata[71:65]);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_CLAIM;
		wipe_table();
		limit_shadow = '1;
		for (int k = 0; k < POOL_SIZE; k++)
			id_pool[k] = (k < 4) ? ID_W'(k + 1) : ID_W'($urandom_range(32'h7FFF_FFFF, 1));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_claim_rules();
		test_lookup();
		test_release();
		test_clear();
		test_feed_limit();
		test_random_traffic(190, 0, 0, 32'hFFFF_FFFF);
		test_random_traffic(190, 56, 0, 32'h0000_FFFF);
		test_random_traffic(190, 0, 56, $urandom);
		test_random_traffic(100, 10, 10, 32'h8000_0000);
		test_random_traffic(30, 10, 10, 32'h0);
		test_drain_pause();

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
